// ===== hw/rtl/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded deque package
// Request codes, beat types and shared constants for the deque core.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int unsigned DEPTH_DEF = 16;
    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned POS_W     = 4;
    localparam int unsigned LEVEL_W   = 5;

    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_FIND       = 3'd4;

    typedef struct packed {
        logic [2:0]                req_type;
        logic signed [VALUE_W-1:0] value;
    } bdq_req_t;

    typedef struct packed {
        logic               ok;
        logic               found;
        logic [POS_W-1:0]   position;
        logic [LEVEL_W-1:0] fill_level;
    } bdq_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } bdq_state_t;

endpackage

// ===== hw/rtl/bounded_deque_with_search_core.sv =====
// ----------------------------------------------------------------------------
// Bounded deque with search, top level
// Push and pop beats: result in the cycle after acceptance, one beat per cycle while not busy.
// Find beats: busy while entries are compared (1 to fill level, 0 if empty),
//   one at a time through the single read port of the entry RAM; result in the cycle after.
// Results are strobed by done for one cycle; the receiver cannot stall.
// Reset empties the deque; the entry RAM itself is not cleared.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_core #(
    parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  bdq_pkg::bdq_req_t cmd,
    output logic              done,
    output bdq_pkg::bdq_rsp_t result
);
    import bdq_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;

    bdq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    bdq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // A result beat never overlaps a running scan.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while scan is running");

    // Every non-find beat answers in the next cycle.
    a_quick_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.req_type != REQ_FIND) |=> done)
        else $error("push or pop beat without result");

    // The end of a scan always produces a result.
    a_scan_reply: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("scan ended without result");

    // A found value is always reported as success.
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.found) |-> result.ok)
        else $error("found without ok");

endmodule

// ===== hw/rtl/bdq_ram.sv =====
// ----------------------------------------------------------------------------
// Deque entry RAM
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module bdq_ram #(
    parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [bdq_pkg::VALUE_W-1:0] wdata,
    input  logic                        re,
    input  logic [AW-1:0]               raddr,
    output logic [bdq_pkg::VALUE_W-1:0] rdata
);
    import bdq_pkg::*;

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/bdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Deque controller
// Keeps head and fill count, drives the entry RAM and runs the find scan.
// ----------------------------------------------------------------------------
module bdq_ctrl #(
    parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEF,
    parameter int unsigned AW    = $clog2(DEPTH),
    parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  bdq_pkg::bdq_req_t           cmd,
    output logic                        done,
    output bdq_pkg::bdq_rsp_t           result,
    output logic                        mem_we,
    output logic [AW-1:0]               mem_waddr,
    output logic [bdq_pkg::VALUE_W-1:0] mem_wdata,
    output logic                        mem_re,
    output logic [AW-1:0]               mem_raddr,
    input  logic [bdq_pkg::VALUE_W-1:0] mem_rdata
);
    import bdq_pkg::*;

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [AW:0]   DEPTH_X  = (AW + 1)'(DEPTH);

    bdq_state_t         state_reg, state_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [CW-1:0]      fill_reg, fill_next;
    logic [AW-1:0]      cmp_idx_reg, cmp_idx_next;
    logic [AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [VALUE_W-1:0] key_reg, key_next;
    logic               done_reg, done_next;
    bdq_rsp_t           result_reg, result_next;

    logic [AW-1:0]      head_prev;
    logic [AW-1:0]      head_succ;
    logic [AW-1:0]      rd_ptr_succ;
    logic [AW:0]        tail_sum;
    logic [AW-1:0]      tail_idx;
    logic               is_full;
    logic               is_empty;
    logic               last_cmp;
    logic [31:0]        cmp_wide;
    logic [31:0]        fill_wide;

    assign is_full   = (fill_reg == FULL_CNT);
    assign is_empty  = (fill_reg == '0);
    assign head_prev = (head_reg == '0) ? LAST_IDX : head_reg - AW'(1);
    assign head_succ = (head_reg == LAST_IDX) ? '0 : head_reg + AW'(1);
    assign rd_ptr_succ = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + AW'(1);

    // The sum stays below twice the depth, so one subtract brings it back.
    assign tail_sum = (AW + 1)'(head_reg) + (AW + 1)'(fill_reg);
    assign tail_idx = (tail_sum >= DEPTH_X) ? AW'(tail_sum - DEPTH_X) : AW'(tail_sum);

    assign last_cmp  = ((CW'(cmp_idx_reg) + CW'(1)) == fill_reg);
    assign cmp_wide  = 32'(cmp_idx_reg);
    assign fill_wide = 32'(fill_next);

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        fill_next    = fill_reg;
        cmp_idx_next = cmp_idx_reg;
        rd_ptr_next  = rd_ptr_reg;
        key_next     = key_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        mem_we       = 1'b0;
        mem_waddr    = head_prev;
        mem_wdata    = cmd.value;
        mem_re       = 1'b0;
        mem_raddr    = head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    done_next            = 1'b1;
                    result_next.ok       = 1'b0;
                    result_next.found    = 1'b0;
                    result_next.position = '0;
                    unique case (cmd.req_type)
                        REQ_PUSH_FRONT:
                        begin
                            if (!is_full)
                            begin
                                head_next      = head_prev;
                                mem_we         = 1'b1;
                                mem_waddr      = head_prev;
                                fill_next      = fill_reg + CW'(1);
                                result_next.ok = 1'b1;
                            end
                        end
                        REQ_PUSH_BACK:
                        begin
                            if (!is_full)
                            begin
                                mem_we         = 1'b1;
                                mem_waddr      = tail_idx;
                                fill_next      = fill_reg + CW'(1);
                                result_next.ok = 1'b1;
                            end
                        end
                        REQ_POP_FRONT:
                        begin
                            if (!is_empty)
                            begin
                                head_next      = head_succ;
                                fill_next      = fill_reg - CW'(1);
                                result_next.ok = 1'b1;
                            end
                        end
                        REQ_POP_BACK:
                        begin
                            if (!is_empty)
                            begin
                                fill_next      = fill_reg - CW'(1);
                                result_next.ok = 1'b1;
                            end
                        end
                        REQ_FIND:
                        begin
                            // An empty deque answers without a scan; otherwise the
                            // front entry is fetched and the scan begins.
                            if (!is_empty)
                            begin
                                done_next    = 1'b0;
                                mem_re       = 1'b1;
                                mem_raddr    = head_reg;
                                cmp_idx_next = '0;
                                rd_ptr_next  = head_succ;
                                key_next     = cmd.value;
                                state_next   = ST_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    result_next.fill_level = fill_wide[LEVEL_W-1:0];
                end
            end
            ST_SCAN:
            begin
                // Read data holds the entry at cmp_idx_reg from the front.
                if (mem_rdata == key_reg)
                begin
                    done_next              = 1'b1;
                    result_next.ok         = 1'b1;
                    result_next.found      = 1'b1;
                    result_next.position   = cmp_wide[POS_W-1:0];
                    result_next.fill_level = fill_wide[LEVEL_W-1:0];
                    state_next             = ST_IDLE;
                end
                else if (last_cmp)
                begin
                    done_next              = 1'b1;
                    result_next.ok         = 1'b0;
                    result_next.found      = 1'b0;
                    result_next.position   = '0;
                    result_next.fill_level = fill_wide[LEVEL_W-1:0];
                    state_next             = ST_IDLE;
                end
                else
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = rd_ptr_reg;
                    cmp_idx_next = cmp_idx_reg + AW'(1);
                    rd_ptr_next  = rd_ptr_succ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            fill_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        rd_ptr_reg  <= rd_ptr_next;
        key_reg     <= key_next;
        result_reg  <= result_next;
    end

    assign busy   = (state_reg == ST_SCAN);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
